[src/rwc_pkg.sv]
// rwc_pkg: shared constants and register codes for the raster window convolution
// depends on nothing; imported by the top level
`default_nettype none

package rwc_pkg;

  // default sizes of the datapath
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_KERNEL = 5;
  localparam int unsigned DEF_PIXEL_BITS = 8;
  localparam int unsigned DEF_COEF_BITS  = 12;

  // fixed frame limits and register widths
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned ROW_BITS   = 12;
  localparam int unsigned KSIZE_W    = 3;
  localparam int unsigned IWIDTH_W   = 11;
  localparam int unsigned IHEIGHT_W  = 13;
  localparam int unsigned KROW_W     = 60;
  localparam int unsigned NUM_KROWS  = 5;
  localparam int unsigned CFG_DATA_W = 60;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned RESULT_W   = 16;

  // output queue depth, a power of two
  localparam int unsigned FIFO_DEPTH = 8;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_SIZE  = 3'd0,
    REG_IMAGE_WIDTH  = 3'd1,
    REG_IMAGE_HEIGHT = 3'd2,
    REG_KROW_ZERO    = 3'd3,
    REG_KROW_ONE     = 3'd4,
    REG_KROW_TWO     = 3'd5,
    REG_KROW_THREE   = 3'd6,
    REG_KROW_FOUR    = 3'd7
  } reg_index_t;

endpackage

`default_nettype wire

[src/rwc_line_store.sv]
// rwc_line_store: one memory per buffered image row, read at the current column
// standalone; instantiated by the top level
`default_nettype none

module rwc_line_store #(
  parameter int unsigned ROWS  = 4,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned PB    = 8
) (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic [$clog2(DEPTH)-1:0]        addr,
  input  wire logic [$clog2(ROWS)-1:0]         wr_slot,
  input  wire logic [PB-1:0]                   pix,
  output logic      [ROWS-1:0][PB-1:0]         rd
);

  // each row memory returns its old entry and takes the pixel when it is the write row
  for (genvar gi = 0; gi < ROWS; gi++) begin : g_row
    logic [PB-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
      if (en) begin
        rd[gi] <= mem[addr];
        if (wr_slot == ($clog2(ROWS))'(gi)) begin
          mem[addr] <= pix;
        end
      end
    end
  end

endmodule

`default_nettype wire

[src/rwc_cell.sv]
// rwc_cell: one window column; shifts to its left neighbor and forms its weighted sum
// standalone; instantiated in a row by the top level
`default_nettype none

module rwc_cell #(
  parameter int unsigned MK    = 5,
  parameter int unsigned PB    = 8,
  parameter int unsigned CB    = 12,
  parameter int unsigned SUM_W = 24
) (
  input  wire logic                        clk,
  input  wire logic                        shift_en,
  input  wire logic [MK-1:0][PB-1:0]       col_in,
  input  wire logic [MK-1:0][CB-1:0]       coef,
  output logic      [MK-1:0][PB-1:0]       col,
  output logic signed [SUM_W-1:0]          col_sum
);

  localparam int unsigned PW = PB + 1 + CB;

  logic signed [PW-1:0] prod [MK];
  logic signed [SUM_W-1:0] sum_c;

  // column register, loaded from the neighbor on every item
  always_ff @(posedge clk) begin
    if (shift_en) begin
      col <= col_in;
    end
  end

  // one product per window row
  always_ff @(posedge clk) begin
    for (int k = 0; k < MK; k++) begin
      prod[k] <= PW'($signed({1'b0, col[k]}) * $signed(coef[k]));
    end
  end

  // column sum
  always_comb begin
    sum_c = '0;
    for (int k = 0; k < MK; k++) begin
      sum_c = sum_c + SUM_W'(prod[k]);
    end
  end

  always_ff @(posedge clk) begin
    col_sum <= sum_c;
  end

endmodule

`default_nettype wire

[src/raster_window_convolution_top.sv]
// raster window convolution: 8-bit raster pixels in, one kernel result per pixel out
// depends on rwc_pkg, rwc_line_store and rwc_cell
// an accepted pixel is registered, shifted into the cells, multiplied, summed per column, totalled and queued
// throughput: one pixel per cycle unless stalled; the line store memories take one read and one write a cycle
// an 8-entry output queue lets pixels keep coming while a result waits to be taken
// reset clears counters, queue pointers and configuration registers to defaults; the line store is not cleared
`default_nettype none

module raster_window_convolution_top
  import rwc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_KERNEL = DEF_MAX_KERNEL,
  parameter int unsigned PIXEL_BITS = DEF_PIXEL_BITS,
  parameter int unsigned COEF_BITS  = DEF_COEF_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data,
  input  wire logic                          pix_valid,
  output logic                               pix_stall,
  input  wire logic [PIXEL_BITS-1:0]         pixel_value,
  output logic                               res_valid,
  input  wire logic                          res_stall,
  output logic signed [RESULT_W-1:0]         conv_value,
  output logic                               center_valid,
  output logic [$clog2(MAX_WIDTH)-1:0]       center_col,
  output logic [ROW_BITS-1:0]                center_row,
  output logic                               end_of_frame
);

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned LROWS  = MAX_KERNEL - 1;
  localparam int unsigned SLOT_W = $clog2(LROWS);
  localparam int unsigned PW     = PIXEL_BITS + 1 + COEF_BITS;
  localparam int unsigned CSUM_W = PW + 3;
  localparam int unsigned TSUM_W = CSUM_W + 3;
  localparam int unsigned PTR_W  = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned NSTG   = 5;

  typedef struct packed {
    logic                  v;
    logic                  inner;
    logic                  eof;
    logic [ROW_BITS-1:0]   row;
    logic [COL_W-1:0]      col;
  } ctl_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] conv;
    logic                       inner;
    logic                       eof;
    logic [ROW_BITS-1:0]        row;
    logic [COL_W-1:0]           col;
  } res_t;

  // configuration registers
  logic [KSIZE_W-1:0]                    kernel_size;
  logic [IWIDTH_W-1:0]                   image_width;
  logic [IHEIGHT_W-1:0]                  image_height;
  logic [NUM_KROWS-1:0][KROW_W-1:0]      krows;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_size  <= KSIZE_W'(3);
      image_width  <= IWIDTH_W'(512);
      image_height <= IHEIGHT_W'(512);
      krows        <= '0;
    end else if (cfg_wr_en) begin
      unique case (reg_index_t'(cfg_index))
        REG_KERNEL_SIZE:  kernel_size  <= cfg_data[KSIZE_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IWIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[IHEIGHT_W-1:0];
        REG_KROW_ZERO:    krows[0]     <= cfg_data[KROW_W-1:0];
        REG_KROW_ONE:     krows[1]     <= cfg_data[KROW_W-1:0];
        REG_KROW_TWO:     krows[2]     <= cfg_data[KROW_W-1:0];
        REG_KROW_THREE:   krows[3]     <= cfg_data[KROW_W-1:0];
        REG_KROW_FOUR:    krows[4]     <= cfg_data[KROW_W-1:0];
        default:          krows        <= krows;
      endcase
    end
  end

  // clamped sizes
  logic [KSIZE_W-1:0]   dim;
  logic [KSIZE_W-1:0]   half;
  logic [KSIZE_W-1:0]   lag;
  logic [KSIZE_W-1:0]   base;
  logic [IHEIGHT_W-1:0] w_eff;
  logic [IHEIGHT_W-1:0] h_eff;

  always_comb begin
    if (kernel_size == '0) begin
      dim = KSIZE_W'(1);
    end else if (kernel_size > KSIZE_W'(MAX_KERNEL)) begin
      dim = KSIZE_W'(MAX_KERNEL);
    end else begin
      dim = kernel_size;
    end
    half = dim >> 1;
    lag  = dim - KSIZE_W'(1) - half;
    base = KSIZE_W'(MAX_KERNEL) - dim;
    if (image_width == '0) begin
      w_eff = IHEIGHT_W'(1);
    end else if (IHEIGHT_W'(image_width) > IHEIGHT_W'(MAX_WIDTH)) begin
      w_eff = IHEIGHT_W'(MAX_WIDTH);
    end else begin
      w_eff = IHEIGHT_W'(image_width);
    end
    if (image_height == '0) begin
      h_eff = IHEIGHT_W'(1);
    end else if (image_height > IHEIGHT_W'(MAX_HEIGHT)) begin
      h_eff = IHEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  // coefficient of kernel row kr, column mc; bits past the register read as zero
  function automatic logic [COEF_BITS-1:0] coef_pick(
    input logic [NUM_KROWS-1:0][KROW_W-1:0] rows,
    input int unsigned kr,
    input int unsigned mc
  );
    logic [63:0] rv;
    rv = '0;
    if (kr < NUM_KROWS && (mc + 1) * COEF_BITS <= 64) begin
      rv = 64'(rows[kr]) >> (mc * COEF_BITS);
    end
    return rv[COEF_BITS-1:0];
  endfunction

  // kernel aligned to the bottom-right of the window, indexed [column][row]
  logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][COEF_BITS-1:0] coef_eff;

  for (genvar gm = 0; gm < MAX_KERNEL; gm++) begin : g_cm
    for (genvar gk = 0; gk < MAX_KERNEL; gk++) begin : g_ck
      always_ff @(posedge clk) begin
        if (KSIZE_W'(gk) >= base && KSIZE_W'(gm) >= base) begin
          coef_eff[gm][gk] <= coef_pick(krows, gk - int'(base), gm - int'(base));
        end else begin
          coef_eff[gm][gk] <= '0;
        end
      end
    end
  end

  // handshakes and occupancy
  logic             acc;
  logic             pop;
  logic [CNT_W-1:0] pend;
  logic [CNT_W-1:0] fifo_cnt;

  assign pix_stall = (pend >= CNT_W'(FIFO_DEPTH));
  assign acc       = pix_valid && !pix_stall;
  assign res_valid = (fifo_cnt != '0);
  assign pop       = res_valid && !res_stall;

  // raster position
  logic [COL_W-1:0]    col_cnt;
  logic [ROW_BITS-1:0] row_cnt;
  logic [SLOT_W-1:0]   slot;
  logic [IHEIGHT_W-1:0] col_inc;
  logic [IHEIGHT_W-1:0] row_inc;

  assign col_inc = IHEIGHT_W'(col_cnt) + IHEIGHT_W'(1);
  assign row_inc = IHEIGHT_W'(row_cnt) + IHEIGHT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
      slot    <= '0;
    end else if (acc) begin
      if (col_inc >= w_eff) begin
        col_cnt <= '0;
        if (row_inc >= h_eff) begin
          row_cnt <= '0;
          slot    <= '0;
        end else begin
          row_cnt <= row_inc[ROW_BITS-1:0];
          slot    <= (slot == SLOT_W'(LROWS - 1)) ? '0 : slot + SLOT_W'(1);
        end
      end else begin
        col_cnt <= col_inc[COL_W-1:0];
      end
    end
  end

  // centre position and interior test
  logic signed [15:0] ci_s;
  logic signed [15:0] cj_s;
  logic signed [15:0] half_s;
  logic               inner;
  logic               eof;

  always_comb begin
    half_s = $signed(16'(half));
    ci_s   = $signed(16'(row_cnt)) - $signed(16'(lag));
    cj_s   = $signed(16'(col_cnt)) - $signed(16'(lag));
    inner  = (ci_s >= half_s) && (ci_s < $signed(16'(h_eff)) - half_s)
          && (cj_s >= half_s) && (cj_s < $signed(16'(w_eff)) - half_s);
    eof    = (col_inc >= w_eff) && (row_inc >= h_eff);
  end

  // line store
  logic [LROWS-1:0][PIXEL_BITS-1:0] line_rd;

  rwc_line_store #(
    .ROWS  (LROWS),
    .DEPTH (MAX_WIDTH),
    .PB    (PIXEL_BITS)
  ) u_line_store (
    .clk     (clk),
    .en      (acc),
    .addr    (col_cnt),
    .wr_slot (slot),
    .pix     (pixel_value),
    .rd      (line_rd)
  );

  // control pipeline
  ctl_t                   ctl [NSTG];
  logic [SLOT_W-1:0]      s1_slot;
  logic [PIXEL_BITS-1:0]  s1_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSTG; i++) begin
        ctl[i].v <= 1'b0;
      end
    end else begin
      ctl[0].v <= acc;
      for (int i = 1; i < NSTG; i++) begin
        ctl[i].v <= ctl[i-1].v;
      end
    end
    ctl[0].inner <= inner;
    ctl[0].eof   <= eof;
    ctl[0].row   <= ci_s[ROW_BITS-1:0];
    ctl[0].col   <= cj_s[COL_W-1:0];
    for (int i = 1; i < NSTG; i++) begin
      ctl[i].inner <= ctl[i-1].inner;
      ctl[i].eof   <= ctl[i-1].eof;
      ctl[i].row   <= ctl[i-1].row;
      ctl[i].col   <= ctl[i-1].col;
    end
    if (acc) begin
      s1_slot <= slot;
      s1_pix  <= pixel_value;
    end
  end

  // new window column: buffered rows oldest first, then the new pixel
  logic [MAX_KERNEL-1:0][PIXEL_BITS-1:0] col_new;
  logic [SLOT_W:0]                        sidx [LROWS];

  always_comb begin
    for (int k = 0; k < LROWS; k++) begin
      sidx[k] = (SLOT_W+1)'(s1_slot) + (SLOT_W+1)'(k);
      if (sidx[k] >= (SLOT_W+1)'(LROWS)) begin
        sidx[k] = sidx[k] - (SLOT_W+1)'(LROWS);
      end
      col_new[k] = line_rd[sidx[k][SLOT_W-1:0]];
    end
    col_new[MAX_KERNEL-1] = s1_pix;
  end

  // row of window cells, newest column on the right
  logic [MAX_KERNEL-1:0][PIXEL_BITS-1:0] cell_col [MAX_KERNEL];
  logic signed [CSUM_W-1:0]               cell_sum [MAX_KERNEL];

  for (genvar gm = 0; gm < MAX_KERNEL; gm++) begin : g_cell
    rwc_cell #(
      .MK    (MAX_KERNEL),
      .PB    (PIXEL_BITS),
      .CB    (COEF_BITS),
      .SUM_W (CSUM_W)
    ) u_cell (
      .clk      (clk),
      .shift_en (ctl[0].v),
      .col_in   ((gm == MAX_KERNEL - 1) ? col_new : cell_col[(gm + 1) % MAX_KERNEL]),
      .coef     (coef_eff[gm]),
      .col      (cell_col[gm]),
      .col_sum  (cell_sum[gm])
    );
  end

  // window total
  logic signed [TSUM_W-1:0] total;
  logic signed [TSUM_W-1:0] total_c;

  always_comb begin
    total_c = '0;
    for (int m = 0; m < MAX_KERNEL; m++) begin
      total_c = total_c + TSUM_W'(cell_sum[m]);
    end
  end

  always_ff @(posedge clk) begin
    total <= total_c;
  end

  // scale toward zero and saturate; border results are set to zero
  logic signed [TSUM_W-1:0]   biased;
  logic signed [TSUM_W-1:0]   scaled;
  logic signed [RESULT_W-1:0] conv_c;

  always_comb begin
    biased = total;
    if (total < 0) begin
      biased = total + TSUM_W'((1 << (COEF_BITS - 1)) - 1);
    end
    scaled = biased >>> (COEF_BITS - 1);
    if (!ctl[NSTG-1].inner) begin
      conv_c = '0;
    end else if (scaled > TSUM_W'(32767)) begin
      conv_c = RESULT_W'(32767);
    end else if (scaled < -TSUM_W'(32768)) begin
      conv_c = RESULT_W'(-32768);
    end else begin
      conv_c = scaled[RESULT_W-1:0];
    end
  end

  // output queue
  res_t             fifo [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             push;

  assign push = ctl[NSTG-1].v;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr].conv  <= conv_c;
      fifo[wr_ptr].inner <= ctl[NSTG-1].inner;
      fifo[wr_ptr].eof   <= ctl[NSTG-1].eof;
      fifo[wr_ptr].row   <= ctl[NSTG-1].row;
      fifo[wr_ptr].col   <= ctl[NSTG-1].col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
      pend     <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      fifo_cnt <= fifo_cnt + CNT_W'(push) - CNT_W'(pop);
      pend     <= pend + CNT_W'(acc) - CNT_W'(pop);
    end
  end

  assign conv_value   = fifo[rd_ptr].conv;
  assign center_valid = fifo[rd_ptr].inner;
  assign end_of_frame = fifo[rd_ptr].eof;
  assign center_row   = fifo[rd_ptr].row;
  assign center_col   = fifo[rd_ptr].col;

  // queue never holds more items than are outstanding
  a_fifo_le_pend: assert property (@(posedge clk) disable iff (rst)
    fifo_cnt <= pend) else $error("output queue holds more items than outstanding");

  // outstanding items stay within the queue depth
  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend <= CNT_W'(FIFO_DEPTH)) else $error("outstanding items exceed queue depth");

  // border results carry zero
  a_border_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !center_valid |-> conv_value == '0) else $error("border result not zero");

  // an accepted item raises the outstanding count unless one leaves
  a_pend_track: assert property (@(posedge clk) disable iff (rst)
    acc && !pop |=> pend == $past(pend) + CNT_W'(1)) else $error("outstanding count slip");

endmodule

`default_nettype wire
